// File: rtl/udpc_pkg.sv
package udpc_pkg;

	localparam logic [15:0] UDP_PROTO = 16'd17;
	localparam logic [16:0] MAX_TOTAL = 17'd65527;
	localparam logic [16:0] MIN_LEN   = 17'd8;
	localparam logic [16:0] SEEN_MAX  = 17'h1ffff;
	localparam logic [16:0] SEEN_SAT  = 17'h1fffd;

	localparam logic [16:0] OFF_SPORT = 17'd0;
	localparam logic [16:0] OFF_DPORT = 17'd2;
	localparam logic [16:0] OFF_LEN   = 17'd4;
	localparam logic [16:0] OFF_SUM   = 17'd6;
	localparam logic [16:0] HDR_BYTES = 17'd8;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_LEN_ERR  = 2'd1;
	localparam logic [1:0] ST_MISMATCH = 2'd2;
	localparam logic [1:0] ST_TOO_BIG  = 2'd3;

	typedef struct packed {
		logic        opcode;
		logic [15:0] word;
		logic        first;
		logic        last;
		logic [16:0] count;
		logic [15:0] ph_src;
		logic [15:0] ph_dst;
	} item_t;

	typedef struct packed {
		logic [15:0] data_sum;
		logic [15:0] ph_sum;
		logic        mode;
		logic [16:0] avail;
		logic [15:0] length;
		logic [15:0] sum_field;
		logic [15:0] sport;
		logic [15:0] dport;
	} res_t;

	// ones' complement add with end-around carry
	function automatic logic [15:0] eac_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'd0, s[16]};
	endfunction

endpackage

// File: rtl/udpc_track.sv
module udpc_track (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            advance,
	input  udpc_pkg::item_t item,
	output udpc_pkg::res_t  res
);

	logic [15:0] sum_q;
	logic [15:0] ph_q;
	logic [16:0] seen_q;
	logic        mode_q;
	logic [16:0] avail_q;
	logic [15:0] sport_q;
	logic [15:0] dport_q;
	logic [15:0] length_q;
	logic [15:0] sumf_q;

	logic [16:0] off;
	logic [17:0] off_p1;
	logic [17:0] off_p2;
	logic        mode;
	logic [16:0] avail;
	logic [15:0] sum_base;
	logic [15:0] ph_base;
	logic [15:0] v;
	logic [15:0] sport_n;
	logic [15:0] dport_n;
	logic [15:0] length_n;
	logic [15:0] sumf_n;
	logic [16:0] limit;
	logic        in_hdr;
	logic        add_full;
	logic        add_half;
	logic [15:0] addend;
	logic [15:0] sum_n;
	logic [16:0] seen_n;

	always_comb begin
		off      = item.first ? 17'd0 : seen_q;
		mode     = item.first ? item.opcode : mode_q;
		avail    = item.first ? item.count : avail_q;
		sum_base = item.first ? 16'd0 : sum_q;
		ph_base  = item.first ?
			udpc_pkg::eac_add(udpc_pkg::eac_add(item.ph_src, item.ph_dst), udpc_pkg::UDP_PROTO) :
			ph_q;
		sport_n  = item.first ? 16'd0 : sport_q;
		dport_n  = item.first ? 16'd0 : dport_q;
		length_n = item.first ? 16'd0 : length_q;
		sumf_n   = item.first ? 16'd0 : sumf_q;
		v        = item.word;
		off_p1   = {1'b0, off} + 18'd1;
		off_p2   = {1'b0, off} + 18'd2;

		if (off == udpc_pkg::OFF_SPORT) begin
			sport_n = item.word;
		end else if (off == udpc_pkg::OFF_DPORT) begin
			dport_n = item.word;
		end else if (off == udpc_pkg::OFF_LEN) begin
			if (mode) begin
				v = avail[15:0];
			end
			length_n = v;
		end else if (off == udpc_pkg::OFF_SUM) begin
			if (mode) begin
				v = 16'd0;
			end
			sumf_n = v;
		end

		// receive header words always count
		in_hdr   = !mode && (off < udpc_pkg::HDR_BYTES);
		limit    = mode ? avail : {1'b0, length_n};
		add_full = in_hdr || (off_p2 <= {1'b0, limit});
		add_half = !in_hdr && (off_p1 == {1'b0, limit});
		if (add_full) begin
			addend = v;
		end else if (add_half) begin
			addend = {v[15:8], 8'h00};
		end else begin
			addend = 16'd0;
		end
		sum_n  = udpc_pkg::eac_add(sum_base, addend);
		seen_n = (off >= udpc_pkg::SEEN_SAT) ? udpc_pkg::SEEN_MAX : off_p2[16:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q    <= '0;
			ph_q     <= '0;
			seen_q   <= '0;
			mode_q   <= 1'b0;
			avail_q  <= '0;
			sport_q  <= '0;
			dport_q  <= '0;
			length_q <= '0;
			sumf_q   <= '0;
		end else if (advance) begin
			if (item.last) begin
				sum_q    <= '0;
				ph_q     <= '0;
				seen_q   <= '0;
				mode_q   <= 1'b0;
				avail_q  <= '0;
				sport_q  <= '0;
				dport_q  <= '0;
				length_q <= '0;
				sumf_q   <= '0;
			end else begin
				sum_q    <= sum_n;
				ph_q     <= ph_base;
				seen_q   <= seen_n;
				mode_q   <= mode;
				avail_q  <= avail;
				sport_q  <= sport_n;
				dport_q  <= dport_n;
				length_q <= length_n;
				sumf_q   <= sumf_n;
			end
		end
	end

	always_comb begin
		res.data_sum  = sum_n;
		res.ph_sum    = ph_base;
		res.mode      = mode;
		res.avail     = avail;
		res.length    = length_n;
		res.sum_field = sumf_n;
		res.sport     = sport_n;
		res.dport     = dport_n;
	end

endmodule

// File: rtl/udp_checksum_engine.sv
// one 16-bit word accepted per cycle, back to back, while out_stall is low
// the result for a datagram appears once its last word has passed the stages listed below
// stages: input register, running sum update, checksum and status register
// a held result stalls input only once two more last words queue behind it
// arst_n clears all valid flags and the running sum, offset and header state
module udp_checksum_engine (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        opcode,
	input  logic [15:0] data_word,
	input  logic        first,
	input  logic        last,
	input  logic        odd_tail,
	input  logic [31:0] source_address,
	input  logic [31:0] dest_address,
	input  logic [16:0] byte_count,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [15:0] checksum_word,
	output logic [15:0] source_port,
	output logic [15:0] dest_port,
	output logic [15:0] length_field
);

	logic            v1_s1;
	udpc_pkg::item_t item_s1;
	logic            v2_s2;
	udpc_pkg::res_t  res_s2;
	udpc_pkg::res_t  res;
	logic            vo_q;
	logic [1:0]      status_q;
	logic [15:0]     cs_q;
	logic [15:0]     sport_q;
	logic [15:0]     dport_q;
	logic [15:0]     len_q;

	logic            out_free;
	logic            s2_free;
	logic            s1_go;
	logic            advance;
	logic            in_take;
	udpc_pkg::item_t item_in;

	logic [15:0]     len_term;
	logic [15:0]     total;
	logic [15:0]     cs_raw;
	logic [1:0]      status_n;
	logic [15:0]     cs_n;
	logic [15:0]     len_n;

	assign out_free = !vo_q || !out_stall;
	assign s2_free  = !v2_s2 || out_free;
	assign s1_go    = !item_s1.last || s2_free;
	assign advance  = v1_s1 && s1_go;
	assign in_stall = v1_s1 && !s1_go;
	assign in_take  = in_valid && !in_stall;

	always_comb begin
		item_in.opcode = opcode;
		item_in.word   = (last && odd_tail) ? {data_word[15:8], 8'h00} : data_word;
		item_in.first  = first;
		item_in.last   = last;
		item_in.count  = byte_count;
		item_in.ph_src = udpc_pkg::eac_add(source_address[31:16], source_address[15:0]);
		item_in.ph_dst = udpc_pkg::eac_add(dest_address[31:16], dest_address[15:0]);
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (!in_stall) begin
			v1_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			item_s1 <= item_in;
		end
	end

	udpc_track u_track (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.res     (res)
	);

	// end of datagram capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v2_s2 <= 1'b0;
		end else if (s2_free) begin
			v2_s2 <= advance && item_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && advance && item_s1.last) begin
			res_s2 <= res;
		end
	end

	always_comb begin
		len_term = res_s2.mode ? res_s2.avail[15:0] : res_s2.length;
		total    = udpc_pkg::eac_add(udpc_pkg::eac_add(res_s2.data_sum, res_s2.ph_sum),
			len_term);
		cs_raw   = ~total;
		if (res_s2.mode) begin
			len_n = res_s2.avail[15:0];
			if (res_s2.avail < udpc_pkg::MIN_LEN) begin
				status_n = udpc_pkg::ST_LEN_ERR;
				cs_n     = 16'd0;
			end else if (res_s2.avail > udpc_pkg::MAX_TOTAL) begin
				status_n = udpc_pkg::ST_TOO_BIG;
				cs_n     = 16'd0;
			end else begin
				status_n = udpc_pkg::ST_OK;
				cs_n     = (cs_raw == 16'd0) ? 16'hffff : cs_raw;
			end
		end else begin
			len_n = res_s2.length;
			if (({1'b0, res_s2.length} < udpc_pkg::MIN_LEN) ||
				({1'b0, res_s2.length} > res_s2.avail)) begin
				status_n = udpc_pkg::ST_LEN_ERR;
				cs_n     = 16'd0;
			end else begin
				cs_n     = cs_raw;
				status_n = (res_s2.sum_field != 16'd0 && cs_raw != 16'd0) ?
					udpc_pkg::ST_MISMATCH : udpc_pkg::ST_OK;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vo_q <= 1'b0;
		end else if (out_free) begin
			vo_q <= v2_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v2_s2) begin
			status_q <= status_n;
			cs_q     <= cs_n;
			sport_q  <= res_s2.sport;
			dport_q  <= res_s2.dport;
			len_q    <= len_n;
		end
	end

	assign out_valid     = vo_q;
	assign status        = status_q;
	assign checksum_word = cs_q;
	assign source_port   = sport_q;
	assign dest_port     = dport_q;
	assign length_field  = len_q;

`ifndef SYNTHESIS
	a_err_zero_cs: assert property (@(posedge clk) disable iff (!arst_n)
		vo_q && (status_q == udpc_pkg::ST_LEN_ERR || status_q == udpc_pkg::ST_TOO_BIG)
		|-> cs_q == 16'd0)
		else $error("error result with nonzero checksum");
	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v2_s2 && !out_free |=> v2_s2)
		else $error("pending result lost");
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> v1_s1 && item_s1.last && v2_s2)
		else $error("stall without a blocked last word");
	a_out_from_s2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(vo_q) |-> $past(v2_s2))
		else $error("result appeared without a capture");
`endif

endmodule

// File: test/tb_udp_checksum_engine.sv
`timescale 1ns / 100ps

module tb_udp_checksum_engine;

	localparam logic OP_RECEIVE  = 1'b0;
	localparam logic OP_TRANSMIT = 1'b1;
	localparam int   CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic        op;
		logic [15:0] word;
		logic        fst;
		logic        lst;
		logic        odd;
		logic [31:0] sa;
		logic [31:0] da;
		logic [16:0] cnt;
	} udp_word_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] csum;
		logic [15:0] sport;
		logic [15:0] dport;
		logic [15:0] length;
	} udp_verdict_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        opcode;
	logic [15:0] data_word;
	logic        first;
	logic        last;
	logic        odd_tail;
	logic [31:0] source_address;
	logic [31:0] dest_address;
	logic [16:0] byte_count;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [15:0] checksum_word;
	logic [15:0] source_port;
	logic [15:0] dest_port;
	logic [15:0] length_field;

	udp_verdict_t pending_verdicts [$];
	int           error_count = 0;
	int           words_sent = 0;
	int           cycle_count = 0;
	int           rx_hold_cycles = 0;
	bit           tx_pace = 1'b0;
	bit           tx_rush = 1'b0;

	// predicted datagram state
	logic [16:0] sum_acc;
	logic [16:0] byte_offset;
	logic [16:0] count_avail;
	logic        tx_mode;
	logic [15:0] sport_seen;
	logic [15:0] dport_seen;
	logic [15:0] udp_length_seen;
	logic [15:0] csum_field_seen;

	udp_checksum_engine DUT (.*);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still outstanding", $time,
				pending_verdicts.size());
			$display("tb_udp_checksum_engine: FAIL");
			$finish;
		end
	end

	function automatic logic [16:0] ones_add(input logic [16:0] acc, input logic [15:0] val);
		logic [17:0] s;
		s = {1'b0, acc} + {2'b00, val};
		return {1'b0, s[15:0]} + {15'd0, s[17:16]};
	endfunction

	function automatic logic [15:0] ones_fold(input logic [16:0] s);
		logic [16:0] t;
		t = {1'b0, s[15:0]} + {16'd0, s[16]};
		t = {1'b0, t[15:0]} + {16'd0, t[16]};
		return t[15:0];
	endfunction

	function automatic void clear_datagram_state();
		sum_acc = '0;
		byte_offset = '0;
		count_avail = '0;
		tx_mode = OP_RECEIVE;
		sport_seen = '0;
		dport_seen = '0;
		udp_length_seen = '0;
		csum_field_seen = '0;
	endfunction

	function automatic bit udp_verdict(input udp_word_t w, output udp_verdict_t v);
		logic [15:0] d;
		logic [15:0] add;
		int unsigned off;
		int unsigned lim;
		v = '0;
		if (w.fst) begin
			clear_datagram_state();
			tx_mode = w.op;
			count_avail = w.cnt;
			sum_acc = ones_add(sum_acc, w.sa[31:16]);
			sum_acc = ones_add(sum_acc, w.sa[15:0]);
			sum_acc = ones_add(sum_acc, w.da[31:16]);
			sum_acc = ones_add(sum_acc, w.da[15:0]);
			sum_acc = ones_add(sum_acc, udpc_pkg::UDP_PROTO);
		end
		d = (w.lst && w.odd) ? (w.word & 16'hff00) : w.word;
		off = byte_offset;
		add = d;
		if (off == udpc_pkg::OFF_SPORT) begin
			sport_seen = d;
		end else if (off == udpc_pkg::OFF_DPORT) begin
			dport_seen = d;
		end else if (off == udpc_pkg::OFF_LEN) begin
			if (tx_mode) add = count_avail[15:0];
			udp_length_seen = add;
		end else if (off == udpc_pkg::OFF_SUM) begin
			if (tx_mode) add = 16'h0000;
			csum_field_seen = add;
		end
		// header words always count on receive
		if (!tx_mode && off < udpc_pkg::HDR_BYTES)
			lim = off + 2;
		else
			lim = tx_mode ? count_avail : udp_length_seen;
		if (off + 2 <= lim)
			sum_acc = ones_add(sum_acc, add);
		else if (off + 1 == lim)
			sum_acc = ones_add(sum_acc, add & 16'hff00);
		byte_offset = (off >= udpc_pkg::SEEN_SAT) ? udpc_pkg::SEEN_MAX : 17'(off + 2);
		if (!w.lst)
			return 1'b0;
		if (tx_mode) begin
			v.length = count_avail[15:0];
			if (count_avail < udpc_pkg::MIN_LEN) begin
				v.status = udpc_pkg::ST_LEN_ERR;
			end else if (count_avail > udpc_pkg::MAX_TOTAL) begin
				v.status = udpc_pkg::ST_TOO_BIG;
			end else begin
				v.csum = ~ones_fold(ones_add(sum_acc, count_avail[15:0]));
				if (v.csum == 16'h0000) v.csum = 16'hffff;
				v.status = udpc_pkg::ST_OK;
			end
		end else begin
			v.length = udp_length_seen;
			if (udp_length_seen < udpc_pkg::MIN_LEN || udp_length_seen > count_avail) begin
				v.status = udpc_pkg::ST_LEN_ERR;
			end else begin
				v.csum = ~ones_fold(ones_add(sum_acc, udp_length_seen));
				v.status = (csum_field_seen != 0 && v.csum != 0) ?
					udpc_pkg::ST_MISMATCH : udpc_pkg::ST_OK;
			end
		end
		v.sport = sport_seen;
		v.dport = dport_seen;
		clear_datagram_state();
		return 1'b1;
	endfunction

	function automatic udp_word_t make_word(input logic op, input logic [15:0] word,
			input logic fst, input logic lst, input logic odd, input logic [31:0] sa,
			input logic [31:0] da, input logic [16:0] cnt);
		udp_word_t w;
		w.op = op;
		w.word = word;
		w.fst = fst;
		w.lst = lst;
		w.odd = odd;
		w.sa = sa;
		w.da = da;
		w.cnt = cnt;
		return w;
	endfunction

	task automatic send_word(input udp_word_t w);
		udp_verdict_t v;
		int gap;
		gap = (tx_pace && !tx_rush) ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= w.op;
		data_word <= w.word;
		first <= w.fst;
		last <= w.lst;
		odd_tail <= w.odd;
		source_address <= w.sa;
		dest_address <= w.da;
		byte_count <= w.cnt;
		do @(posedge clk); while (in_stall);
		words_sent++;
		if (udp_verdict(w, v)) pending_verdicts.push_back(v);
	endtask

	// csum_kind: 0 correct checksum field, 1 zero field, 2 random field
	task automatic send_datagram(input logic op, input logic [31:0] sa, input logic [31:0] da,
			input logic [16:0] cnt, input logic [15:0] len_word, input int csum_kind,
			input int nw);
		logic [15:0] words [$];
		logic [16:0] acc;
		logic        tail;
		int          lim;
		int          i;
		tx_pace = ($urandom_range(0, 2) != 0);
		for (i = 0; i < nw; i++) words.push_back(16'($urandom));
		tail = cnt[0] ^ ($urandom_range(0, 7) == 0);
		if (tail) words[nw - 1] = words[nw - 1] & 16'hff00;
		if (op == OP_RECEIVE && nw > 3) begin
			words[2] = len_word;
			words[3] = 16'h0000;
			lim = len_word;
			if (lim % 2 == 1 && (lim - 1) / 2 < nw)
				words[(lim - 1) / 2] = words[(lim - 1) / 2] & 16'hff00;
			acc = ones_add(17'd0, sa[31:16]);
			acc = ones_add(acc, sa[15:0]);
			acc = ones_add(acc, da[31:16]);
			acc = ones_add(acc, da[15:0]);
			acc = ones_add(acc, udpc_pkg::UDP_PROTO);
			for (i = 0; i < nw && 2 * i < lim; i++) acc = ones_add(acc, words[i]);
			acc = ones_add(acc, len_word);
			case (csum_kind)
				0: words[3] = ~ones_fold(acc);
				1: words[3] = 16'h0000;
				default: words[3] = 16'($urandom_range(1, 16'hffff));
			endcase
		end else if (op == OP_RECEIVE && nw > 2) begin
			words[2] = len_word;
		end
		for (i = 0; i < nw; i++) begin
			send_word(make_word((i == 0) ? op : 1'($urandom), words[i], i == 0, i == nw - 1,
				(i == nw - 1) ? tail : 1'($urandom), (i == 0) ? sa : $urandom,
				(i == 0) ? da : $urandom, (i == 0) ? cnt : 17'($urandom)));
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			error_count++;
		end
	endtask

	always @(posedge clk) begin : check_results
		udp_verdict_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_verdicts.size() == 0) begin
				$display("%0t: result with nothing outstanding, expected none, actual status %0d",
					$time, status);
				error_count++;
			end else begin
				want = pending_verdicts.pop_front();
				check_field("status", 16'(want.status), 16'(status));
				check_field("checksum_word", want.csum, checksum_word);
				check_field("source_port", want.sport, source_port);
				check_field("dest_port", want.dport, dest_port);
				check_field("length_field", want.length, length_field);
			end
		end
	end

	// receiver: a fresh wait after every transfer, plus any long hold requested
	initial begin : drive_out_stall
		int stall_left;
		bit rx_busy;
		stall_left = 0;
		rx_busy = 1'b1;
		out_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && out_stall === 1'b0) begin
				if ($urandom_range(0, 7) == 0) rx_busy = !rx_busy;
				stall_left = rx_busy ? $urandom_range(0, 19) : 0;
			end
			if (rx_hold_cycles > 0) begin
				stall_left += rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			out_stall <= (stall_left > 0);
			if (stall_left > 0) stall_left--;
		end
	end

	task automatic test_corner_datagrams();
		tx_pace = 1'($urandom);
		// no start after reset
		send_word(make_word(OP_TRANSMIT, 16'hffff, 1'b0, 1'b1, 1'b1, 32'hffffffff,
			32'hffffffff, 17'h1ffff));
		send_word(make_word(OP_RECEIVE, 16'h0000, 1'b1, 1'b1, 1'b0, 32'hffffffff, 32'h0,
			17'h1ffff));
		send_datagram(OP_RECEIVE, 32'hffffffff, 32'hffffffff, 17'd8, 16'd8, 0, 4);
		// transmit sum folds to all ones, so zero is sent as 0xffff
		send_word(make_word(OP_TRANSMIT, 16'hffde, 1'b1, 1'b0, 1'b0, 32'h0, 32'h0, 17'd8));
		send_word(make_word(OP_RECEIVE, 16'h0000, 1'b0, 1'b0, 1'b1, '1, '1, '1));
		send_word(make_word(OP_RECEIVE, 16'hffff, 1'b0, 1'b0, 1'b0, '1, '1, '1));
		send_word(make_word(OP_RECEIVE, 16'hffff, 1'b0, 1'b1, 1'b0, '1, '1, '1));
		send_word(make_word(OP_TRANSMIT, 16'h5555, 1'b1, 1'b1, 1'b0, $urandom, $urandom,
			udpc_pkg::MAX_TOTAL + 17'd1));
		send_word(make_word(OP_TRANSMIT, 16'haaaa, 1'b1, 1'b1, 1'b0, $urandom, $urandom,
			17'h1ffff));
		send_datagram(OP_TRANSMIT, 32'h0, 32'h0, 17'd3, 16'd0, 0, 2);
		send_datagram(OP_RECEIVE, $urandom, $urandom, 17'd9, 16'd9, 0, 5);
		send_datagram(OP_RECEIVE, $urandom, $urandom, 17'd8, 16'd8, 1, 4);
		send_datagram(OP_RECEIVE, $urandom, $urandom, 17'd8, 16'd8, 2, 4);
	endtask

	task automatic test_receive_stream(input int budget);
		int start_count;
		int len;
		int cnt;
		int lfield;
		int nw;
		int kind;
		start_count = words_sent;
		while (words_sent - start_count < budget) begin
			len = ($urandom_range(0, 19) == 0) ? $urandom_range(49, 300) : $urandom_range(8, 48);
			cnt = len;
			lfield = len;
			case ($urandom_range(0, 11))
				0: cnt = len + $urandom_range(1, 9);
				1: cnt = $urandom_range(0, 7);
				2: lfield = $urandom_range(0, 7);
				3: lfield = len + $urandom_range(1, 40);
				4: begin
					cnt = 17'h1ffff;
					lfield = 16'hffff;
				end
				default: ;
			endcase
			nw = (cnt + 1) / 2;
			if (nw < 1) nw = 1;
			if (nw > 160) begin
				nw = $urandom_range(4, 12);
			end else begin
				case ($urandom_range(0, 9))
					0: nw = $urandom_range(1, nw);
					1: nw = nw + $urandom_range(1, 3);
					default: ;
				endcase
			end
			kind = $urandom_range(0, 4);
			kind = (kind < 3) ? 0 : kind - 2;
			send_datagram(OP_RECEIVE, $urandom, $urandom, 17'(cnt), 16'(lfield), kind, nw);
		end
	endtask

	task automatic test_transmit_stream(input int budget);
		int start_count;
		int cnt;
		int nw;
		start_count = words_sent;
		while (words_sent - start_count < budget) begin
			case ($urandom_range(0, 9))
				0: cnt = $urandom_range(0, 7);
				1: cnt = $urandom_range(int'(udpc_pkg::MAX_TOTAL) + 1, int'(udpc_pkg::SEEN_MAX));
				2: cnt = udpc_pkg::MAX_TOTAL;
				3: cnt = $urandom_range(49, 300);
				default: cnt = $urandom_range(8, 48);
			endcase
			nw = (cnt + 1) / 2;
			if (nw < 1) nw = 1;
			if (nw > 150) begin
				nw = $urandom_range(1, 8);
			end else begin
				case ($urandom_range(0, 9))
					0: nw = $urandom_range(1, nw);
					1: nw = nw + $urandom_range(1, 3);
					default: ;
				endcase
			end
			send_datagram(OP_TRANSMIT, $urandom, $urandom, 17'(cnt), 16'($urandom), 0, nw);
		end
	endtask

	// stray starts and ends, missing starts, every field random
	task automatic test_broken_stream(input int budget);
		int start_count;
		start_count = words_sent;
		while (words_sent - start_count < budget) begin
			if ($urandom_range(0, 7) == 0) tx_pace = !tx_pace;
			send_word(make_word(1'($urandom), 16'($urandom), $urandom_range(0, 4) == 0,
				$urandom_range(0, 4) == 0, 1'($urandom), $urandom, $urandom,
				$urandom_range(0, 1) ? 17'($urandom_range(0, 64)) : 17'($urandom)));
		end
	endtask

	// receiver holds off while words keep coming, so the block backs up its input
	task automatic test_output_hold(input int budget);
		int start_count;
		int len;
		start_count = words_sent;
		tx_rush = 1'b1;
		rx_hold_cycles = 300;
		while (words_sent - start_count < budget) begin
			len = $urandom_range(8, 12);
			send_datagram(1'($urandom), $urandom, $urandom, 17'(len), 16'(len), 0, (len + 1) / 2);
		end
		tx_rush = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		opcode <= OP_RECEIVE;
		data_word <= '0;
		first <= 1'b0;
		last <= 1'b0;
		odd_tail <= 1'b0;
		source_address <= '0;
		dest_address <= '0;
		byte_count <= '0;
		clear_datagram_state();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_datagrams();
		test_receive_stream(300);
		test_transmit_stream(250);
		test_broken_stream(100);
		test_output_hold(80);
		in_valid <= 1'b0;
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("tb_udp_checksum_engine: PASS");
		else
			$display("tb_udp_checksum_engine: FAIL");
		$finish;
	end

endmodule
